### hw/rtl/pal_pkg.sv
// shared types and constants for the positional array list
// no dependencies; imported by pal_store, positional_array_list and the testbench
package pal_pkg;

   // list geometry
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   // transaction field widths
   localparam int POS_W    = 10;
   localparam int FOUND_W  = 10;
   localparam int COUNT_W  = 11;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_CLEAR  = 2'd3
   } pal_op_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_FULL     = 3'd1,
      STATUS_BADPOS   = 3'd2,
      STATUS_EMPTY    = 3'd3,
      STATUS_NOTFOUND = 3'd4
   } pal_status_type;

   typedef struct packed {
      pal_op_type         opcode;
      logic [POS_W-1:0]   position;
      logic signed [DATA_W-1:0] value;
   } pal_req_type;

   typedef struct packed {
      pal_status_type     status;
      logic [FOUND_W-1:0] found_index;
      logic [COUNT_W-1:0] element_count;
   } pal_rsp_type;

   // store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } pal_wr_type;

endpackage

### hw/rtl/pal_store.sv
// element store: one write port, one read port with registered data
// depends on pal_pkg
module pal_store
   import pal_pkg::*;
(
   input  logic              clock,
   input  pal_wr_type        wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/positional_array_list.sv
// positional array list: ordered list of signed 32-bit values with
// insert, delete, find and clear; depends on pal_pkg and pal_store
//
// - req channel (req_valid/req_ready/req_data) carries one operation per
//   transaction: opcode, position and value
// - rsp channel (rsp_valid/rsp_ready/rsp_data) returns one result per
//   request: status, found index and element count after the operation
// - one request at a time; req_ready is high only while the sequencer idles
// - operation steps, receiver ready: clear, rejects and a delete of the last
//     element go straight to the result; append writes the value first;
//     insert moves elements up, then writes; delete moves them down;
//     find reads elements until a match or the end of the list
// - the sequencer returns to idle as the result is loaded, so the next request can be taken while it waits
// - one store read and one write per cycle bound the shift and search time
// - the result waits in an output register; while it is not taken the
//   sequencer holds its next result, so a stalled receiver stalls the block
// - reset empties the list; store contents are not cleared
module positional_array_list
   import pal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pal_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pal_rsp_type rsp_data
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SHIFT_UP = 6'b000010,
      S_SHIFT_DN = 6'b000100,
      S_SEARCH   = 6'b001000,
      S_PUT      = 6'b010000,
      S_DONE     = 6'b100000
   } pal_state_type;

   pal_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic               pend_last_ff, pend_last_in;
   pal_req_type        req_ff, req_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [ADDR_W-1:0]  end_ff, end_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   pal_status_type     status_ff, status_in;
   logic [ADDR_W-1:0]  found_ff, found_in;
   pal_rsp_type        rsp_data_ff, rsp_data_in;

   pal_wr_type         wr;
   logic               rd_en;
   logic [DATA_W-1:0]  rd_data;
   logic               last_issue;
   logic [CNT_W-1:0]   req_pos_ext;

   pal_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign last_issue  = (ptr_ff == end_ff);
   assign req_pos_ext = CNT_W'(req_data.position);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_last_in = 1'b0;
      pend_addr_in = ptr_ff;
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      wr           = '0;
      rd_en        = 1'b0;

      // output register drains on its own handshake
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               status_in = STATUS_OK;
               found_in  = '0;
               issue_in  = 1'b0;
               state_in  = S_DONE;
               unique case (req_data.opcode)
                  OP_INSERT: begin
                     priority if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else if (req_pos_ext > count_ff) begin
                        status_in = STATUS_BADPOS;
                     end else if (req_pos_ext == count_ff) begin
                        state_in = S_PUT;
                     end else begin
                        // move entries count-1 down to position up by one
                        ptr_in   = ADDR_W'(count_ff - CNT_W'(1));
                        end_in   = ADDR_W'(req_data.position);
                        issue_in = 1'b1;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  OP_DELETE: begin
                     priority if (req_pos_ext >= count_ff) begin
                        status_in = STATUS_BADPOS;
                     end else if (req_pos_ext + CNT_W'(1) == count_ff) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        // move entries position+1 up to count-1 down by one
                        ptr_in   = ADDR_W'(req_pos_ext + CNT_W'(1));
                        end_in   = ADDR_W'(count_ff - CNT_W'(1));
                        issue_in = 1'b1;
                        state_in = S_SHIFT_DN;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        ptr_in   = '0;
                        end_in   = ADDR_W'(count_ff - CNT_W'(1));
                        issue_in = 1'b1;
                        state_in = S_SEARCH;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end

         S_SHIFT_UP: begin
            // read one entry per cycle, write it one place higher
            rd_en = issue_ff;
            if (issue_ff) begin
               pend_in      = 1'b1;
               pend_last_in = last_issue;
               ptr_in       = ptr_ff - ADDR_W'(1);
               if (last_issue) begin
                  issue_in = 1'b0;
               end
            end
            if (pend_ff) begin
               wr.en   = 1'b1;
               wr.addr = pend_addr_ff + ADDR_W'(1);
               wr.data = rd_data;
            end
            if (pend_last_ff) begin
               state_in = S_PUT;
            end
         end

         S_SHIFT_DN: begin
            // read one entry per cycle, write it one place lower
            rd_en = issue_ff;
            if (issue_ff) begin
               pend_in      = 1'b1;
               pend_last_in = last_issue;
               ptr_in       = ptr_ff + ADDR_W'(1);
               if (last_issue) begin
                  issue_in = 1'b0;
               end
            end
            if (pend_ff) begin
               wr.en   = 1'b1;
               wr.addr = pend_addr_ff - ADDR_W'(1);
               wr.data = rd_data;
            end
            if (pend_last_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_SEARCH: begin
            // compare each read entry against the search value
            rd_en = issue_ff;
            if (issue_ff) begin
               pend_in      = 1'b1;
               pend_last_in = last_issue;
               ptr_in       = ptr_ff + ADDR_W'(1);
               if (last_issue) begin
                  issue_in = 1'b0;
               end
            end
            priority if (pend_ff && (rd_data == req_ff.value)) begin
               found_in     = pend_addr_ff;
               status_in    = STATUS_OK;
               issue_in     = 1'b0;
               pend_in      = 1'b0;
               pend_last_in = 1'b0;
               state_in     = S_DONE;
            end else if (pend_last_ff) begin
               status_in = STATUS_NOTFOUND;
               state_in  = S_DONE;
            end
         end

         S_PUT: begin
            // place the new value at its position
            wr.en    = 1'b1;
            wr.addr  = ADDR_W'(req_ff.position);
            wr.data  = req_ff.value;
            count_in = count_ff + CNT_W'(1);
            state_in = S_DONE;
         end

         S_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.found_index   = FOUND_W'(found_ff);
               rsp_data_in.element_count = COUNT_W'(count_ff);
               state_in                  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // element count never goes past capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // the store is never written while idle or handing over a result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !wr.en)
      else $error("store write outside a shift or put");

   // an accepted request always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start");

   // a result is loaded only from the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result loaded outside done state");

   // a found index lies inside the list
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_OK && rsp_data_ff.found_index != '0)
         |-> (COUNT_W'(rsp_data_ff.found_index) < rsp_data_ff.element_count))
      else $error("found index beyond element count");
`endif

endmodule

### tb/sv/positional_array_list_tb.sv
// self-checking testbench for positional_array_list: directed, long-list and random
// list operations checked against a shadow list. depends on pal_pkg and the rtl
`timescale 1ns / 1ps

module positional_array_list_tb;
   import pal_pkg::*;

   localparam int LIMIT        = 8_000_000;
   localparam int FILL_ITEMS   = 300;
   localparam int RANDOM_ITEMS = 245;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 1100;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   pal_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   pal_rsp_type rsp_data;

   // shadow of the list contents and length, updated per accepted transaction
   logic signed [DATA_W-1:0] shadow_list [CAPACITY];
   int                       shadow_len = 0;

   pal_req_type pending_ops[$];
   pal_rsp_type expected_results[$];

   int  gap_left      = 0;
   int  stall_left    = 0;
   int  hold_left     = 0;
   int  next_hold_at  = 60;
   bit  sender_calm   = 1'b0;
   bit  receiver_calm = 1'b0;
   int  fail_cnt      = 0;
   int  checked_cnt   = 0;
   int  peak_len      = 0;
   int  op_seen [4]     = '{default: 0};
   int  status_seen [5] = '{default: 0};

   positional_array_list uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // list operation on the shadow copy, returns the result it should give
   function automatic pal_rsp_type apply_list_op(input pal_req_type r);
      pal_rsp_type res;
      int          pos;
      int          k;
      res.status        = STATUS_OK;
      res.found_index   = '0;
      pos               = int'(r.position);
      case (r.opcode)
         OP_INSERT: begin
            if (shadow_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else if (pos > shadow_len) begin
               res.status = STATUS_BADPOS;
            end else begin
               for (k = shadow_len; k > pos; k--)
                  shadow_list[k] = shadow_list[k-1];
               shadow_list[pos] = r.value;
               shadow_len++;
            end
         end
         OP_DELETE: begin
            if (pos >= shadow_len) begin
               res.status = STATUS_BADPOS;
            end else begin
               for (k = pos + 1; k < shadow_len; k++)
                  shadow_list[k-1] = shadow_list[k];
               shadow_len--;
            end
         end
         OP_FIND: begin
            if (shadow_len == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               // first match wins, last element included
               res.status = STATUS_NOTFOUND;
               for (k = 0; k < shadow_len; k++) begin
                  if (shadow_list[k] == r.value) begin
                     res.status      = STATUS_OK;
                     res.found_index = FOUND_W'(k);
                     break;
                  end
               end
            end
         end
         default: begin
            shadow_len = 0;
         end
      endcase
      res.element_count = COUNT_W'(shadow_len);
      return res;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_len(input bit calm);
      int r;
      r = $urandom_range(99);
      if (calm || r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 15);
      else return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [DATA_W-1:0] fill_value(input int i);
      return DATA_W'(i) * 32'h9E37_79B1;
   endfunction

   task automatic queue_item(input pal_op_type op, input int pos,
                             input logic signed [DATA_W-1:0] val);
      pal_req_type r;
      r.opcode   = op;
      r.position = POS_W'(pos);
      r.value    = val;
      pending_ops.push_back(r);
   endtask

   // directed: field extremes, every opcode, empty and edge positions
   task automatic queue_directed();
      queue_item(OP_FIND,   0,    32'sd0);
      queue_item(OP_DELETE, 0,    32'sd0);
      queue_item(OP_INSERT, 1,    32'sd9);
      queue_item(OP_INSERT, 0,    32'h7FFF_FFFF);
      queue_item(OP_INSERT, 1,    32'h8000_0000);
      queue_item(OP_INSERT, 0,    32'hFFFF_FFFF);
      queue_item(OP_INSERT, 1,    32'sd0);
      queue_item(OP_INSERT, 1023, 32'sd5);
      queue_item(OP_FIND,   1023, 32'h8000_0000);
      queue_item(OP_FIND,   0,    32'h7FFF_FFFF);
      queue_item(OP_FIND,   0,    32'sd1);
      queue_item(OP_FIND,   0,    32'hFFFF_FFFF);
      queue_item(OP_INSERT, 4,    32'sd0);
      queue_item(OP_FIND,   0,    32'sd0);
      queue_item(OP_DELETE, 5,    32'sd0);
      queue_item(OP_DELETE, 4,    32'sd0);
      queue_item(OP_DELETE, 1,    32'h7FFF_FFFF);
      queue_item(OP_DELETE, 1023, 32'sd0);
      queue_item(OP_FIND,   0,    32'h7FFF_FFFE);
      queue_item(OP_CLEAR,  1023, 32'hFFFF_FFFF);
      queue_item(OP_FIND,   0,    32'h8000_0000);
      queue_item(OP_DELETE, 0,    32'sd0);
      queue_item(OP_INSERT, 0,    32'h1234_5678);
      queue_item(OP_FIND,   0,    32'h1234_5678);
      queue_item(OP_CLEAR,  0,    32'sd0);
   endtask

   // grow a long list by mid-list inserts, then long shifts and full searches
   task automatic queue_long_sweep();
      int i;
      for (i = 0; i < FILL_ITEMS; i++)
         queue_item(OP_INSERT, i / 2, fill_value(i));
      queue_item(OP_INSERT, FILL_ITEMS + 1, 32'sd1);
      queue_item(OP_FIND,   0,    fill_value(FILL_ITEMS - 1));
      queue_item(OP_FIND,   0,    fill_value(FILL_ITEMS));
      queue_item(OP_FIND,   0,    fill_value(0));
      queue_item(OP_DELETE, 0,    32'sd0);
      queue_item(OP_DELETE, 1023, 32'sd0);
      queue_item(OP_INSERT, FILL_ITEMS - 1, fill_value(1));
      queue_item(OP_FIND,   0,    fill_value(1));
      queue_item(OP_INSERT, 0,    fill_value(0));
      queue_item(OP_CLEAR,  0,    32'sd0);
   endtask

   // short random burst steered by the current list length
   task automatic queue_random_batch(inout int left);
      int                       n;
      int                       len;
      int                       pos;
      int                       sel;
      pal_op_type               op;
      logic signed [DATA_W-1:0] val;
      n   = $urandom_range(1, 8);
      len = shadow_len;
      while (n > 0 && left > 0) begin
         // keep the list short so most operations stay cheap
         sel = $urandom_range(99);
         if (sel < ((len > 40) ? 20 : 45)) op = OP_INSERT;
         else if (sel < 65) op = OP_DELETE;
         else if (sel < 96) op = OP_FIND;
         else op = OP_CLEAR;

         sel = $urandom_range(99);
         if (sel < 10) pos = $urandom_range(1023);
         else if (sel < 20) pos = len;
         else if (op == OP_INSERT) pos = $urandom_range(len);
         else pos = (len > 0) ? $urandom_range(len - 1) : 0;

         sel = $urandom_range(99);
         if (op == OP_FIND && shadow_len > 0 && sel < 60) begin
            val = shadow_list[$urandom_range(shadow_len - 1)];
         end else if (sel < 70) begin
            val = int'($urandom_range(8)) - 4;
         end else if (sel < 80) begin
            case ($urandom_range(3))
               0: val = 32'h8000_0000;
               1: val = 32'h7FFF_FFFF;
               2: val = 32'sd0;
               default: val = 32'hFFFF_FFFF;
            endcase
         end else begin
            val = $urandom;
         end

         case (op)
            OP_INSERT: if (len < CAPACITY && pos <= len) len++;
            OP_DELETE: if (pos < len) len--;
            OP_CLEAR:  len = 0;
            default:   ;
         endcase
         queue_item(op, pos, val);
         n--;
         left--;
      end
   endtask

   task automatic check_result(input pal_rsp_type got);
      pal_rsp_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result: status %0d found_index %0d element_count %0d",
                got.status, got.found_index, got.element_count);
         fail_cnt++;
      end else begin
         want = expected_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt++;
         end
         if (got.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
            fail_cnt++;
         end
         if (got.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, got.element_count);
            fail_cnt++;
         end
         status_seen[int'(want.status)]++;
      end
      checked_cnt++;
   endtask

   // driver: offers queued transactions with random gaps, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_list_op(req_data));
            op_seen[int'(req_data.opcode)]++;
            if (shadow_len > peak_len) peak_len = shadow_len;
         end
         if (!req_valid || req_ready) begin
            if ($urandom_range(63) == 0) sender_calm = !sender_calm;
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               req_data  <= pending_ops.pop_front();
               req_valid <= 1'b1;
               gap_left = idle_len(sender_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks results and drives rsp_ready with stalls and long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if ($urandom_range(63) == 0) receiver_calm = !receiver_calm;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (checked_cnt >= next_hold_at) begin
            // long hold-off so the block backs up into its input
            hold_left = HOLD_CYCLES;
            next_hold_at += 800;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(2) == 0) stall_left = idle_len(receiver_calm);
         end
      end
   end

   // watchdog
   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results checked", LIMIT, checked_cnt);
      $display("positional_array_list_tb: FAIL");
      $finish;
   end

   // stimulus sequence and end of test
   initial begin
      int random_left;
      random_left = RANDOM_ITEMS;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      queue_long_sweep();
      while (pending_ops.size() != 0) @(posedge clock);
      while (random_left > 0) begin
         queue_random_batch(random_left);
         while (pending_ops.size() != 0) @(posedge clock);
      end
      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d transactions: insert %0d, delete %0d, find %0d, clear %0d; peak length %0d",
               checked_cnt, op_seen[0], op_seen[1], op_seen[2], op_seen[3], peak_len);
      $display("results: ok %0d, full %0d, bad position %0d, empty %0d, not found %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (fail_cnt == 0) begin
         $display("positional_array_list_tb: PASS");
      end else begin
         $display("positional_array_list_tb: FAIL");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/pal_pkg.sv
hw/rtl/pal_store.sv
hw/rtl/positional_array_list.sv
tb/sv/positional_array_list_tb.sv
